/* src/assert_macros.svh */
// Assertion helpers used by the checker file srcb_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRCB_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srcb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SRCB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srcb assertion failed");

`endif

/* src/srcb_pkg.sv */
`timescale 1ns / 1ps

package srcb_pkg;

  localparam int MAX_ENTRIES_DEFAULT       = 8;
  localparam int SLOT_COUNT_DEFAULT        = 32;
  localparam int SECTORS_PER_ENTRY_DEFAULT = 16;

  localparam logic [1:0] KIND_ENTRY     = 2'd0;
  localparam logic [1:0] KIND_COMMAND   = 2'd1;
  localparam logic [1:0] KIND_NO_SLOT   = 2'd2;
  localparam logic [1:0] KIND_BAD_COUNT = 2'd3;

  localparam int         ADDR_W               = 3;
  localparam logic       REG_TABLE_BASE       = 1'b0;
  localparam logic [31:0] TABLE_BASE_RESET    = 32'h0020_C000;

  localparam int SECTOR_SHIFT = 9;
  localparam int SLOT_SHIFT   = 8;

  // Reciprocal division of (count - 1) by the sectors per entry.
  localparam int DIV_IN_W  = 13;
  localparam int DIV_SHIFT = 21;
  localparam int RECIP_W   = 22;
  localparam int PROD_W    = DIV_IN_W + RECIP_W;

  typedef struct packed {
    logic load;
    logic calc;
    logic emit_entry;
    logic emit_cmd;
    logic emit_err;
  } ctrl_cmd_t;

  typedef struct packed {
    logic no_slot;
    logic bad_count;
    logic last_entry;
  } dp_status_t;

endpackage

/* src/srcb_ctrl.sv */
`timescale 1ns / 1ps

module srcb_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   request_valid,
  output logic                   request_ready,
  output logic                   record_valid,
  input  logic                   record_ready,
  input  srcb_pkg::dp_status_t   status,
  output srcb_pkg::ctrl_cmd_t    cmd
);
  import srcb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ERROR,
    ST_ENTRY,
    ST_COMMAND
  } state_t;

  state_t state;
  logic   out_free;
  logic   any_emit;

  assign out_free      = !record_valid || record_ready;
  assign request_ready = (state == ST_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.load       = (state == ST_IDLE) && request_valid;
    cmd.calc       = (state == ST_CHECK);
    cmd.emit_err   = (state == ST_ERROR) && out_free;
    cmd.emit_entry = (state == ST_ENTRY) && out_free;
    cmd.emit_cmd   = (state == ST_COMMAND) && out_free;
  end

  assign any_emit = cmd.emit_err || cmd.emit_entry || cmd.emit_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      record_valid <= 1'b0;
    end else begin
      if (any_emit) begin
        record_valid <= 1'b1;
      end else if (record_ready) begin
        record_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (request_valid) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (status.no_slot || status.bad_count) begin
            state <= ST_ERROR;
          end else begin
            state <= ST_ENTRY;
          end
        end
        ST_ERROR: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_ENTRY: begin
          if (out_free && status.last_entry) begin
            state <= ST_COMMAND;
          end
        end
        ST_COMMAND: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/srcb_datapath.sv */
`timescale 1ns / 1ps

module srcb_datapath #(
  parameter int MAX_ENTRIES       = srcb_pkg::MAX_ENTRIES_DEFAULT,
  parameter int SLOT_COUNT        = srcb_pkg::SLOT_COUNT_DEFAULT,
  parameter int SECTORS_PER_ENTRY = srcb_pkg::SECTORS_PER_ENTRY_DEFAULT
) (
  input  logic                  clk,
  input  srcb_pkg::ctrl_cmd_t   cmd,
  output srcb_pkg::dp_status_t  status,
  input  logic [31:0]           command_table_base,
  input  logic [47:0]           start_lba,
  input  logic [15:0]           sector_count,
  input  logic [31:0]           buffer_base,
  input  logic [31:0]           active_slots,
  input  logic [31:0]           issued_slots,
  output logic [1:0]            record_kind,
  output logic [4:0]            slot,
  output logic [31:0]           table_address,
  output logic [2:0]            entry_index,
  output logic [31:0]           segment_address,
  output logic [16:0]           byte_count,
  output logic                  interrupt_on_done,
  output logic [3:0]            entry_total,
  output logic [47:0]           fis_lba,
  output logic [15:0]           fis_sector_count,
  output logic                  last
);
  import srcb_pkg::*;

  localparam int          CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam logic [15:0] MAX_COUNT   = 16'(MAX_ENTRIES * SECTORS_PER_ENTRY);
  localparam logic [31:0] ENTRY_BYTES = 32'(SECTORS_PER_ENTRY * (1 << SECTOR_SHIFT));
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'(((1 << DIV_SHIFT) + SECTORS_PER_ENTRY - 1) / SECTORS_PER_ENTRY);

  logic [47:0]           lba_q;
  logic [15:0]           count_q;
  logic [31:0]           buf_q;
  logic [SLOT_COUNT-1:0] busy_q;
  logic [4:0]            slot_q;
  logic [31:0]           taddr_q;
  logic [PROD_W-1:0]     prod_q;
  logic [CNT_W-1:0]      idx_q;
  logic [31:0]           seg_q;
  logic [15:0]           remain_q;

  logic [4:0]            slot_c;
  logic                  found_c;
  logic [DIV_IN_W-1:0]   count_m1;
  logic [CNT_W-1:0]      total_c;
  logic                  last_c;

  always_comb begin
    slot_c  = '0;
    found_c = 1'b0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        slot_c  = 5'(i);
        found_c = 1'b1;
      end
    end
  end

  assign count_m1 = DIV_IN_W'(count_q - 16'd1);
  assign total_c  = CNT_W'(prod_q[PROD_W-1:DIV_SHIFT]) + CNT_W'(1);
  assign last_c   = (idx_q == total_c - CNT_W'(1));

  assign status.no_slot    = !found_c;
  assign status.bad_count  = (count_q == 16'd0) || (count_q > MAX_COUNT);
  assign status.last_entry = last_c;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lba_q   <= start_lba;
      count_q <= sector_count;
      buf_q   <= buffer_base;
      busy_q  <= SLOT_COUNT'(active_slots | issued_slots);
    end
    if (cmd.calc) begin
      slot_q   <= slot_c;
      taddr_q  <= command_table_base + (32'(slot_c) << SLOT_SHIFT);
      prod_q   <= PROD_W'(count_m1) * PROD_W'(DIV_RECIP);
      idx_q    <= '0;
      seg_q    <= buf_q;
      remain_q <= count_q;
    end
    if (cmd.emit_entry) begin
      record_kind       <= KIND_ENTRY;
      slot              <= slot_q;
      table_address     <= taddr_q;
      entry_index       <= 3'(idx_q);
      segment_address   <= seg_q;
      byte_count        <= last_c ? 17'({remain_q, {SECTOR_SHIFT{1'b0}}})
                                  : 17'(ENTRY_BYTES);
      interrupt_on_done <= !last_c;
      entry_total       <= 4'(total_c);
      fis_lba           <= '0;
      fis_sector_count  <= '0;
      last              <= 1'b0;
      idx_q             <= idx_q + CNT_W'(1);
      seg_q             <= seg_q + ENTRY_BYTES;
      remain_q          <= remain_q - 16'(SECTORS_PER_ENTRY);
    end
    if (cmd.emit_cmd) begin
      record_kind       <= KIND_COMMAND;
      slot              <= slot_q;
      table_address     <= taddr_q;
      entry_index       <= '0;
      segment_address   <= '0;
      byte_count        <= '0;
      interrupt_on_done <= 1'b0;
      entry_total       <= 4'(total_c);
      fis_lba           <= lba_q;
      fis_sector_count  <= count_q;
      last              <= 1'b1;
    end
    if (cmd.emit_err) begin
      record_kind       <= found_c ? KIND_BAD_COUNT : KIND_NO_SLOT;
      slot              <= '0;
      table_address     <= '0;
      entry_index       <= '0;
      segment_address   <= '0;
      byte_count        <= '0;
      interrupt_on_done <= 1'b0;
      entry_total       <= '0;
      fis_lba           <= '0;
      fis_sector_count  <= '0;
      last              <= 1'b1;
    end
  end

endmodule

/* src/sata_read_command_builder_unit.sv */
// A request is registered when accepted; the check state then picks the slot and the entry count.
// Throughput: one record per cycle while the output is not stalled, the entries first and then the
// command record; an error request gives a single error record.
// A new request is taken as soon as the final record sits in the output register.
// Reset is synchronous; the table base register returns to 0x20C000.
`timescale 1ns / 1ps

module sata_read_command_builder_unit #(
  parameter int MAX_ENTRIES       = srcb_pkg::MAX_ENTRIES_DEFAULT,
  parameter int SLOT_COUNT        = srcb_pkg::SLOT_COUNT_DEFAULT,
  parameter int SECTORS_PER_ENTRY = srcb_pkg::SECTORS_PER_ENTRY_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srcb_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        request_valid,
  output logic                        request_ready,
  input  logic [47:0]                 start_lba,
  input  logic [15:0]                 sector_count,
  input  logic [31:0]                 buffer_base,
  input  logic [31:0]                 active_slots,
  input  logic [31:0]                 issued_slots,
  output logic                        record_valid,
  input  logic                        record_ready,
  output logic [1:0]                  record_kind,
  output logic [4:0]                  slot,
  output logic [31:0]                 table_address,
  output logic [2:0]                  entry_index,
  output logic [31:0]                 segment_address,
  output logic [16:0]                 byte_count,
  output logic                        interrupt_on_done,
  output logic [3:0]                  entry_total,
  output logic [47:0]                 fis_lba,
  output logic [15:0]                 fis_sector_count,
  output logic                        last
);
  import srcb_pkg::*;

  logic [31:0] command_table_base;
  logic        reg_index;
  ctrl_cmd_t   cmd;
  dp_status_t  status;

  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_W-1];
  assign prdata    = (reg_index == REG_TABLE_BASE) ? command_table_base : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      command_table_base <= TABLE_BASE_RESET;
    end else if (psel && penable && pwrite && pready && reg_index == REG_TABLE_BASE) begin
      command_table_base <= pwdata;
    end
  end

  srcb_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_ready (request_ready),
    .record_valid  (record_valid),
    .record_ready  (record_ready),
    .status        (status),
    .cmd           (cmd)
  );

  srcb_datapath #(
    .MAX_ENTRIES       (MAX_ENTRIES),
    .SLOT_COUNT        (SLOT_COUNT),
    .SECTORS_PER_ENTRY (SECTORS_PER_ENTRY)
  ) u_datapath (
    .clk                (clk),
    .cmd                (cmd),
    .status             (status),
    .command_table_base (command_table_base),
    .start_lba          (start_lba),
    .sector_count       (sector_count),
    .buffer_base        (buffer_base),
    .active_slots       (active_slots),
    .issued_slots       (issued_slots),
    .record_kind        (record_kind),
    .slot               (slot),
    .table_address      (table_address),
    .entry_index        (entry_index),
    .segment_address    (segment_address),
    .byte_count         (byte_count),
    .interrupt_on_done  (interrupt_on_done),
    .entry_total        (entry_total),
    .fis_lba            (fis_lba),
    .fis_sector_count   (fis_sector_count),
    .last               (last)
  );

endmodule

/* src/srcb_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srcb_checker (
  input logic        clk,
  input logic        rst,
  input logic        request_valid,
  input logic        request_ready,
  input logic        record_valid,
  input logic        record_ready,
  input logic [1:0]  record_kind,
  input logic        interrupt_on_done,
  input logic        last
);
  import srcb_pkg::*;

  `SRCB_ASSERT_NEXT(a_busy_after_accept, clk, rst, request_valid && request_ready, !request_ready)
  `SRCB_ASSERT_NEXT(a_stall_holds, clk, rst, record_valid && !record_ready, record_valid && $stable(record_kind) && $stable(last))
  `SRCB_ASSERT_SAME(a_error_is_last, clk, rst, record_valid && (record_kind == KIND_NO_SLOT || record_kind == KIND_BAD_COUNT), last)
  `SRCB_ASSERT_SAME(a_command_is_last, clk, rst, record_valid && record_kind == KIND_COMMAND, last && !interrupt_on_done)
  `SRCB_ASSERT_SAME(a_entry_not_last, clk, rst, record_valid && record_kind == KIND_ENTRY, !last)

endmodule

bind sata_read_command_builder_unit srcb_checker u_srcb_checker (.*);
